FILE: design/tofl_pkg.sv
package tofl_pkg;

    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int TIME_W = 48;
    localparam int VAL_W  = 64;
    localparam int Q_W    = TIME_W + 1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_READ   = 2'd1,
        OP_LOCAL  = 2'd2,
        OP_UTC    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP_CHK,
        ST_FIRST_CHK,
        ST_LAST_CHK,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  addr;
        logic [TIME_W-1:0] wtime;
        logic [VAL_W-1:0]  wvalue;
    } store_req_t;

endpackage

FILE: design/tofl_if.sv
interface tofl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [47:0] stamp;
    logic [63:0] payload;
    logic [9:0]  slot;

    modport source (output valid, output operation, output stamp, output payload,
                    output slot, input ready);
    modport sink   (input valid, input operation, input stamp, input payload,
                    input slot, output ready);
endinterface

interface tofl_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [9:0]  found_index;
    logic [47:0] found_time;
    logic [63:0] found_value;
    logic [10:0] entry_count;

    modport source (output valid, output ok, output found_index, output found_time,
                    output found_value, output entry_count, input ready);
    modport sink   (input valid, input ok, input found_index, input found_time,
                    input found_value, input entry_count, output ready);
endinterface

interface tofl_cfg_if;
    logic        valid;
    logic        ready;
    logic [47:0] base_utc;

    modport source (output valid, output base_utc, input ready);
    modport sink   (input valid, input base_utc, output ready);
endinterface

FILE: design/tofl_store.sv
module tofl_store (
    input  logic                            clk,
    input  tofl_pkg::store_req_t            req,
    output logic [tofl_pkg::TIME_W-1:0]     rtime,
    output logic [tofl_pkg::VAL_W-1:0]      rvalue
);

    logic [tofl_pkg::TIME_W+tofl_pkg::VAL_W-1:0] mem [tofl_pkg::DEPTH];
    logic [tofl_pkg::TIME_W+tofl_pkg::VAL_W-1:0] rdata_reg;

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= {req.wtime, req.wvalue};
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rtime  = rdata_reg[tofl_pkg::TIME_W+tofl_pkg::VAL_W-1:tofl_pkg::VAL_W];
    assign rvalue = rdata_reg[tofl_pkg::VAL_W-1:0];

endmodule

FILE: design/time_ordered_store_floor_lookup.sv
// Append-only store of time-ordered entries with lookup of the floor entry by time.
//
// Channels: req (operation, stamp, payload, slot), rsp (ok, found_index, found_time,
// found_value, entry_count), cfg (base_utc). All use valid/ready; a transaction
// completes at a rising edge with both high. cfg is always ready; the user must write
// cfg only while the block is idle, which the block itself does not enforce.
//
// One request is in work at a time: req.ready is high only in the idle state.
// Every entry lives in one single-port memory with registered read data, and a
// small sequencer drives compare logic over it, at most one memory read per cycle.
// Appends and reads by index finish without a search. A lookup also finishes without
// one when the store is empty, the query is clamped or equals the last entry, or the
// store holds two entries; otherwise it runs a binary search over the entries.
//
// Reset clears the entry count, base_utc and all handshake state; memory contents
// are not cleared and entries at or beyond the count are never read.
// A result waits in the output register while rsp.ready is low; the next request
// can still be taken and worked, and its result is held back until the first one
// has been taken.
module time_ordered_store_floor_lookup (
    input  logic        clk,
    input  logic        rst_n,
    tofl_req_if.sink    req,
    tofl_rsp_if.source  rsp,
    tofl_cfg_if.sink    cfg
);

    localparam int IDX_W  = tofl_pkg::IDX_W;
    localparam int CNT_W  = tofl_pkg::CNT_W;
    localparam int TIME_W = tofl_pkg::TIME_W;
    localparam int VAL_W  = tofl_pkg::VAL_W;
    localparam int Q_W    = tofl_pkg::Q_W;

    tofl_pkg::state_t          state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [TIME_W-1:0]         base_utc_reg;
    logic signed [Q_W-1:0]     q_reg, q_next;
    logic [VAL_W-1:0]          payload_reg, payload_next;
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]          mid_reg, mid_next;
    logic                      res_ok_reg, res_ok_next;
    logic                      res_data_reg, res_data_next;
    logic [IDX_W-1:0]          res_idx_reg, res_idx_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_ok_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic [TIME_W-1:0]         out_time_reg;
    logic [VAL_W-1:0]          out_value_reg;
    logic [CNT_W-1:0]          out_count_reg;
    logic                      out_load;

    tofl_pkg::store_req_t      mem_req;
    logic [TIME_W-1:0]         rtime;
    logic [VAL_W-1:0]          rvalue;

    logic signed [Q_W-1:0]     stamp_ext;
    logic signed [Q_W-1:0]     base_ext;
    logic signed [Q_W-1:0]     rtime_ext;
    logic [CNT_W-1:0]          count_m1;
    logic                      le;
    logic [CNT_W-1:0]          lo_s, hi_s, span_s;

    tofl_store u_store (
        .clk    (clk),
        .req    (mem_req),
        .rtime  (rtime),
        .rvalue (rvalue)
    );

    assign stamp_ext = $signed({req.stamp[TIME_W-1], req.stamp});
    assign base_ext  = $signed({base_utc_reg[TIME_W-1], base_utc_reg});
    assign rtime_ext = $signed({rtime[TIME_W-1], rtime});
    assign count_m1  = count_reg - CNT_W'(1);

    // Shared compare: entry just read is at or below the query.
    assign le = (rtime_ext <= q_reg);

    // Search step narrows the bracket [lo, hi) around the floor index.
    assign lo_s   = le ? mid_reg : lo_reg;
    assign hi_s   = le ? hi_reg  : mid_reg;
    assign span_s = hi_s - lo_s;

    assign req.ready = (state_reg == tofl_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        q_next        = q_reg;
        payload_next  = payload_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        res_ok_next   = res_ok_reg;
        res_data_next = res_data_reg;
        res_idx_next  = res_idx_reg;
        out_load      = 1'b0;
        mem_req.we     = 1'b0;
        mem_req.re     = 1'b0;
        mem_req.addr   = '0;
        mem_req.wtime  = req.stamp;
        mem_req.wvalue = req.payload;

        case (state_reg)
            tofl_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    res_ok_next   = 1'b0;
                    res_data_next = 1'b0;
                    res_idx_next  = '0;
                    q_next        = stamp_ext;
                    payload_next  = req.payload;
                    state_next    = tofl_pkg::ST_FINISH;
                    case (tofl_pkg::op_t'(req.operation))
                        tofl_pkg::OP_APPEND:
                        begin
                            if (count_reg == CNT_W'(tofl_pkg::DEPTH))
                            begin
                                res_ok_next = 1'b0;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_req.we   = 1'b1;
                                mem_req.addr = '0;
                                count_next   = count_reg + CNT_W'(1);
                                res_ok_next  = 1'b1;
                            end
                            else
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = count_m1[IDX_W-1:0];
                                state_next   = tofl_pkg::ST_APP_CHK;
                            end
                        end
                        tofl_pkg::OP_READ:
                        begin
                            res_idx_next = req.slot;
                            if ({1'b0, req.slot} < count_reg)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.addr  = req.slot;
                                res_ok_next   = 1'b1;
                                res_data_next = 1'b1;
                            end
                        end
                        tofl_pkg::OP_LOCAL,
                        tofl_pkg::OP_UTC:
                        begin
                            if (tofl_pkg::op_t'(req.operation) == tofl_pkg::OP_UTC)
                            begin
                                q_next = stamp_ext - base_ext;
                            end
                            if (count_reg != '0)
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = '0;
                                state_next   = tofl_pkg::ST_FIRST_CHK;
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            tofl_pkg::ST_APP_CHK:
            begin
                // q holds the append time; reject if it goes back in time.
                if (le)
                begin
                    mem_req.we     = 1'b1;
                    mem_req.addr   = count_reg[IDX_W-1:0];
                    mem_req.wtime  = q_reg[TIME_W-1:0];
                    mem_req.wvalue = payload_reg;
                    count_next     = count_reg + CNT_W'(1);
                    res_ok_next    = 1'b1;
                end
                state_next = tofl_pkg::ST_FINISH;
            end

            tofl_pkg::ST_FIRST_CHK:
            begin
                if (q_reg < rtime_ext)
                begin
                    res_idx_next = '0;
                    state_next   = tofl_pkg::ST_FINISH;
                end
                else
                begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = count_m1[IDX_W-1:0];
                    state_next   = tofl_pkg::ST_LAST_CHK;
                end
            end

            tofl_pkg::ST_LAST_CHK:
            begin
                if (q_reg > rtime_ext)
                begin
                    res_idx_next = count_m1[IDX_W-1:0];
                    state_next   = tofl_pkg::ST_FINISH;
                end
                else if (q_reg == rtime_ext)
                begin
                    // Last entry matches: it is the highest index at or below.
                    res_idx_next  = count_m1[IDX_W-1:0];
                    res_ok_next   = 1'b1;
                    res_data_next = 1'b1;
                    state_next    = tofl_pkg::ST_FINISH;
                end
                else
                begin
                    // Entry 0 is at or below, last entry is above.
                    lo_next = '0;
                    hi_next = count_m1;
                    if (count_m1 == CNT_W'(1))
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.addr  = '0;
                        res_idx_next  = '0;
                        res_ok_next   = 1'b1;
                        res_data_next = 1'b1;
                        state_next    = tofl_pkg::ST_FINISH;
                    end
                    else
                    begin
                        mid_next     = count_m1 >> 1;
                        mem_req.re   = 1'b1;
                        mem_req.addr = mid_next[IDX_W-1:0];
                        state_next   = tofl_pkg::ST_SEARCH;
                    end
                end
            end

            tofl_pkg::ST_SEARCH:
            begin
                lo_next = lo_s;
                hi_next = hi_s;
                if (span_s > CNT_W'(1))
                begin
                    mid_next     = lo_s + (span_s >> 1);
                    mem_req.re   = 1'b1;
                    mem_req.addr = mid_next[IDX_W-1:0];
                end
                else
                begin
                    // Fetch the floor entry for the result.
                    mem_req.re    = 1'b1;
                    mem_req.addr  = lo_s[IDX_W-1:0];
                    res_idx_next  = lo_s[IDX_W-1:0];
                    res_ok_next   = 1'b1;
                    res_data_next = 1'b1;
                    state_next    = tofl_pkg::ST_FINISH;
                end
            end

            tofl_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = tofl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tofl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tofl_pkg::ST_IDLE;
            count_reg     <= '0;
            base_utc_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                base_utc_reg <= cfg.base_utc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        payload_reg  <= payload_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        res_ok_reg   <= res_ok_next;
        res_data_reg <= res_data_next;
        res_idx_reg  <= res_idx_next;
        if (out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_idx_reg   <= res_idx_reg;
            out_time_reg  <= res_data_reg ? rtime  : '0;
            out_value_reg <= res_data_reg ? rvalue : '0;
            out_count_reg <= count_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.found_index = out_idx_reg;
    assign rsp.found_time  = out_time_reg;
    assign rsp.found_value = out_value_reg;
    assign rsp.entry_count = out_count_reg;

endmodule

FILE: design/tofl_checker.sv
module tofl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_ok,
    input logic [47:0] rsp_found_time,
    input logic [63:0] rsp_found_value,
    input logic [10:0] rsp_entry_count
);

    // Hold a result until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

    // One request at a time: ready drops after every accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= 11'd1024)
    else $error("entry count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ok |-> rsp_found_time == '0 && rsp_found_value == '0)
    else $error("failed result carries entry data");

endmodule

bind time_ordered_store_floor_lookup tofl_checker u_tofl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_found_time  (rsp.found_time),
    .rsp_found_value (rsp.found_value),
    .rsp_entry_count (rsp.entry_count)
);
